// ===== rtl/psr_pkg.sv =====
`timescale 1ns / 1ps

package psr_pkg;

	localparam int THR_W      = 12;
	localparam int SUM_OUT_W  = 12;
	localparam int RATE_W     = 14;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [THR_W-1:0]   LOW_RESET  = THR_W'(2480);
	localparam logic [THR_W-1:0]   HIGH_RESET = THR_W'(2880);
	localparam logic [RATE_W-1:0]  RATE_MAX   = {RATE_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = CFG_IDX_W'(1);

	typedef struct packed {
		logic [SUM_OUT_W-1:0] smoothed_sum;
		logic                 beat_seen;
		logic [RATE_W-1:0]    pulse_rate;
	} result_t;

endpackage

// ===== rtl/psr_in_if.sv =====
`timescale 1ns / 1ps

interface psr_in_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink (input valid, input kind, input sample, output ready);
endinterface

// ===== rtl/psr_out_if.sv =====
`timescale 1ns / 1ps

interface psr_out_if;
	logic                           valid;
	logic                           ready;
	logic [psr_pkg::SUM_OUT_W-1:0]  smoothed_sum;
	logic                           beat_seen;
	logic [psr_pkg::RATE_W-1:0]     pulse_rate;

	modport source (output valid, output smoothed_sum, output beat_seen, output pulse_rate,
		input ready);
	modport sink (input valid, input smoothed_sum, input beat_seen, input pulse_rate,
		output ready);
endinterface

// ===== rtl/pulse_sensor_heart_rate_core.sv =====
`timescale 1ns / 1ps

// Throughput: one item per cycle while the skid entry is empty; window and history
// sums are kept as running sums, so each sample or tick is a single subtract-add
// update of the state. A two-entry output stage (result register plus skid) keeps
// input taking beats while one result waits. Reset (arst_n low) clears all state but
// the output data registers; thresholds return to 2480/2880.
module pulse_sensor_heart_rate_core #(
	parameter int SAMPLE_BITS = 10,
	parameter int SMOOTH_TAPS = 4,
	parameter int RATE_WINDOW = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_data,
	psr_in_if.sink                            in_ch,
	psr_out_if.source                         out_ch
);

	localparam int SUM_W  = SAMPLE_BITS + $clog2(SMOOTH_TAPS);
	localparam int CMP_W  = (SUM_W > psr_pkg::THR_W) ? SUM_W : psr_pkg::THR_W;
	localparam int HSUM_W = psr_pkg::COUNT_W + $clog2(RATE_WINDOW + 1);
	localparam int PROD_W = HSUM_W + 2;
	localparam int RCMP_W = (PROD_W > psr_pkg::RATE_W) ? PROD_W : psr_pkg::RATE_W;

	logic [psr_pkg::THR_W-1:0]   low_thr_q;
	logic [psr_pkg::THR_W-1:0]   high_thr_q;
	logic [SAMPLE_BITS-1:0]      win_q [SMOOTH_TAPS];
	logic [SUM_W-1:0]            win_sum_q;
	logic [psr_pkg::COUNT_W-1:0] beat_cnt_q;
	logic [psr_pkg::COUNT_W-1:0] hist_q [RATE_WINDOW];
	logic [HSUM_W-1:0]           hist_sum_q;
	logic [psr_pkg::RATE_W-1:0]  rate_q;

	logic                        out_valid_q;
	logic                        skid_valid_q;
	psr_pkg::result_t            out_q;
	psr_pkg::result_t            skid_q;

	logic                        acc;
	logic                        is_tick;
	logic [SAMPLE_BITS-1:0]      samp;
	logic [SUM_W-1:0]            win_sum_nxt;
	logic [CMP_W-1:0]            sum_c;
	logic [CMP_W-1:0]            prev_c;
	logic [CMP_W-1:0]            low_c;
	logic [CMP_W-1:0]            high_c;
	logic                        beat;
	logic [HSUM_W-1:0]           hist_sum_nxt;
	logic [PROD_W-1:0]           rate_full;
	logic [psr_pkg::RATE_W-1:0]  rate_sat;
	psr_pkg::result_t            res;

	assign in_ch.ready = !skid_valid_q;
	assign acc         = in_ch.valid && !skid_valid_q;
	assign is_tick     = (in_ch.kind == psr_pkg::KIND_TICK);
	assign samp        = SAMPLE_BITS'(in_ch.sample);

	// The window sum also serves as the previous sum: ticks leave it untouched.
	always_comb begin
		win_sum_nxt = SUM_W'({1'b0, win_sum_q} + (SUM_W+1)'(samp) - (SUM_W+1)'(win_q[0]));
		sum_c  = CMP_W'(win_sum_nxt);
		prev_c = CMP_W'(win_sum_q);
		low_c  = CMP_W'(low_thr_q);
		high_c = CMP_W'(high_thr_q);
		beat   = !is_tick && (prev_c < low_c) && (sum_c > low_c) && (sum_c < high_c);
	end

	always_comb begin
		hist_sum_nxt = HSUM_W'({1'b0, hist_sum_q} - (HSUM_W+1)'(hist_q[0])
			+ (HSUM_W+1)'(beat_cnt_q));
		// Times three as a shift and an add.
		rate_full = PROD_W'({hist_sum_nxt, 1'b0}) + PROD_W'(hist_sum_nxt);
		if (RCMP_W'(rate_full) > RCMP_W'(psr_pkg::RATE_MAX)) begin
			rate_sat = psr_pkg::RATE_MAX;
		end else begin
			rate_sat = psr_pkg::RATE_W'(rate_full);
		end
	end

	always_comb begin
		res.beat_seen = beat;
		if (is_tick) begin
			res.smoothed_sum = psr_pkg::SUM_OUT_W'(win_sum_q);
			res.pulse_rate   = rate_sat;
		end else begin
			res.smoothed_sum = psr_pkg::SUM_OUT_W'(win_sum_nxt);
			res.pulse_rate   = rate_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= psr_pkg::LOW_RESET;
			high_thr_q <= psr_pkg::HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				psr_pkg::REG_LOW_THRESHOLD:  low_thr_q  <= psr_pkg::THR_W'(cfg_data);
				psr_pkg::REG_HIGH_THRESHOLD: high_thr_q <= psr_pkg::THR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SMOOTH_TAPS; k++) begin
				win_q[k] <= '0;
			end
			for (int k = 0; k < RATE_WINDOW; k++) begin
				hist_q[k] <= '0;
			end
			win_sum_q  <= '0;
			hist_sum_q <= '0;
			beat_cnt_q <= '0;
			rate_q     <= '0;
		end else if (acc) begin
			if (is_tick) begin
				for (int k = 0; k + 1 < RATE_WINDOW; k++) begin
					hist_q[k] <= hist_q[k+1];
				end
				hist_q[RATE_WINDOW-1] <= beat_cnt_q;
				hist_sum_q <= hist_sum_nxt;
				beat_cnt_q <= '0;
				rate_q     <= rate_sat;
			end else begin
				for (int k = 0; k + 1 < SMOOTH_TAPS; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[SMOOTH_TAPS-1] <= samp;
				win_sum_q <= win_sum_nxt;
				if (beat && (beat_cnt_q != psr_pkg::COUNT_MAX)) begin
					beat_cnt_q <= beat_cnt_q + psr_pkg::COUNT_W'(1);
				end
			end
		end
	end

	// Output stage: the skid entry catches a beat taken while the result register stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q  <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ch.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res;
			end
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.smoothed_sum = out_q.smoothed_sum;
	assign out_ch.beat_seen    = out_q.beat_seen;
	assign out_ch.pulse_rate   = out_q.pulse_rate;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	a_tick_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_tick) |=> (beat_cnt_q == '0))
		else $error("beat count not cleared by a tick");

	a_tick_pushes_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_tick) |=> (hist_q[RATE_WINDOW-1] == $past(beat_cnt_q)))
		else $error("history did not take the finished second's count");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_tick) |=> (beat_cnt_q >= $past(beat_cnt_q)))
		else $error("beat count dropped on a sample");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int SAMPLE_BITS  = 10;
	localparam int SMOOTH_TAPS  = 4;
	localparam int RATE_WINDOW  = 20;
	localparam int RATE_SCALE   = 3;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam int SUM_MAX      = SMOOTH_TAPS * SAMPLE_MAX;
	localparam int CLK_PERIOD   = 12;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int RANDOM_PHASES     = 6;
	localparam int ITEMS_PER_PHASE   = 160;
	localparam int SATURATION_CYCLES = 262;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [psr_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [psr_pkg::CFG_DATA_W-1:0] cfg_data;

	psr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
	psr_out_if out_ch ();

	pulse_sensor_heart_rate_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SMOOTH_TAPS(SMOOTH_TAPS),
		.RATE_WINDOW(RATE_WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow state of the block, advanced once per accepted input beat.
	logic [SAMPLE_BITS-1:0]        sample_taps [SMOOTH_TAPS];
	logic [psr_pkg::SUM_OUT_W-1:0] last_sum;
	logic [psr_pkg::COUNT_W-1:0]   pulses_this_second;
	logic [psr_pkg::COUNT_W-1:0]   pulse_history [RATE_WINDOW];
	logic [psr_pkg::RATE_W-1:0]    rate_bpm;
	logic [psr_pkg::THR_W-1:0]     low_thr;
	logic [psr_pkg::THR_W-1:0]     high_thr;

	psr_pkg::result_t expected_results [$];

	int mismatches;
	int results_checked;
	int items_sent;
	int ticks_sent;
	int pulses_predicted;
	int idle_pct;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic psr_pkg::result_t predict_step(input logic kind,
			input logic [SAMPLE_BITS-1:0] sample);
		psr_pkg::result_t              r;
		logic [psr_pkg::SUM_OUT_W-1:0] sum;
		int unsigned                   total;
		logic                          pulse;
		pulse = 1'b0;
		if (kind == psr_pkg::KIND_SAMPLE) begin
			for (int k = 0; k < SMOOTH_TAPS - 1; k++)
				sample_taps[k] = sample_taps[k + 1];
			sample_taps[SMOOTH_TAPS - 1] = sample;
			sum = '0;
			for (int k = 0; k < SMOOTH_TAPS; k++)
				sum += psr_pkg::SUM_OUT_W'(sample_taps[k]);
			// A pulse needs the sum to rise from below the low threshold into the band.
			if (last_sum < low_thr && sum > low_thr && sum < high_thr) begin
				pulse = 1'b1;
				pulses_predicted++;
				if (pulses_this_second != psr_pkg::COUNT_MAX)
					pulses_this_second++;
			end
			last_sum = sum;
		end else begin
			for (int k = 0; k < RATE_WINDOW - 1; k++)
				pulse_history[k] = pulse_history[k + 1];
			pulse_history[RATE_WINDOW - 1] = pulses_this_second;
			pulses_this_second = '0;
			total = 0;
			for (int k = 0; k < RATE_WINDOW; k++)
				total += pulse_history[k];
			total *= RATE_SCALE;
			rate_bpm = (total > psr_pkg::RATE_MAX) ? psr_pkg::RATE_MAX
				: psr_pkg::RATE_W'(total);
		end
		r.smoothed_sum = last_sum;
		r.beat_seen    = pulse;
		r.pulse_rate   = rate_bpm;
		return r;
	endfunction

	// Sends one item; returns at the rising edge where the beat is taken.
	task automatic send_item(input logic kind, input int sample);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_ch.valid  <= 1'b0;
			in_ch.kind   <= $urandom_range(1);
			in_ch.sample <= $urandom_range(SAMPLE_MAX);
			@(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.kind   <= kind;
		in_ch.sample <= SAMPLE_BITS'(sample);
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		expected_results.push_back(predict_step(kind, SAMPLE_BITS'(sample)));
		items_sent++;
		if (kind == psr_pkg::KIND_TICK)
			ticks_sent++;
	endtask

	task automatic send_samples(input int value, input int count);
		repeat (count) send_item(psr_pkg::KIND_SAMPLE, value);
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [psr_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= psr_pkg::CFG_DATA_W'(value);
		if (idx == psr_pkg::REG_LOW_THRESHOLD)
			low_thr = psr_pkg::THR_W'(value);
		else if (idx == psr_pkg::REG_HIGH_THRESHOLD)
			high_thr = psr_pkg::THR_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(input int lo, input int hi);
		drain_results();
		write_reg(psr_pkg::REG_LOW_THRESHOLD, lo);
		write_reg(psr_pkg::REG_HIGH_THRESHOLD, hi);
	endtask

	// Reset thresholds: sums that land on the band edges, full scale, and ticks.
	task automatic test_directed_extremes();
		send_item(psr_pkg::KIND_SAMPLE, 0);
		send_item(psr_pkg::KIND_TICK, SAMPLE_MAX);
		send_samples(650, 4);
		send_samples(SAMPLE_MAX, 4);
		// Walks down to a sum equal to the low threshold, which must not count.
		send_samples(620, 4);
		// Starts from a sum equal to the low threshold and ends on the high one.
		send_samples(720, 4);
		send_item(psr_pkg::KIND_TICK, 0);
	endtask

	task automatic test_threshold_settings();
		// Narrow band that admits exactly one sum value.
		set_thresholds(999, 1001);
		send_samples(0, 4);
		send_samples(250, 4);
		// Crossed thresholds: nothing can count.
		set_thresholds(1000, 999);
		send_item(psr_pkg::KIND_SAMPLE, 0);
		send_item(psr_pkg::KIND_SAMPLE, SAMPLE_MAX);
		send_item(psr_pkg::KIND_TICK, 1);
	endtask

	// A period-three pattern produces a pulse every third sample, past 255 per second.
	task automatic test_pulse_counter_saturation();
		set_thresholds(1500, SUM_MAX);
		repeat (SATURATION_CYCLES) begin
			send_item(psr_pkg::KIND_SAMPLE, 0);
			send_item(psr_pkg::KIND_SAMPLE, 0);
			send_item(psr_pkg::KIND_SAMPLE, SAMPLE_MAX);
		end
		send_item(psr_pkg::KIND_TICK, 0);
		send_item(psr_pkg::KIND_TICK, SAMPLE_MAX);
	endtask

	task automatic test_random_pulse_trains();
		int base;
		int swing;
		int period;
		int width;
		int pos;
		int level;
		int pick;
		int lo;
		int hi;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			base  = $urandom_range(0, 700);
			swing = $urandom_range(40, SAMPLE_MAX - base);
			if (phase == 0) begin
				lo = 0;
				hi = SUM_MAX;
			end else if (phase == 1) begin
				lo = SUM_MAX;
				hi = 0;
			end else begin
				lo = SMOOTH_TAPS * base + $urandom_range(0, SMOOTH_TAPS * swing);
				hi = lo + $urandom_range(1, 1200);
				if (hi > SUM_MAX)
					hi = SUM_MAX;
			end
			set_thresholds(lo, hi);
			// One phase runs both sides flat out.
			idle_pct = (phase == 3) ? 0 : 15;
			period = $urandom_range(5, 24);
			width  = $urandom_range(1, period - 1);
			pos    = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					send_item(psr_pkg::KIND_TICK, $urandom_range(SAMPLE_MAX));
				end else if (pick < 12) begin
					send_item(psr_pkg::KIND_SAMPLE, $urandom_range(SAMPLE_MAX));
				end else begin
					level = ((pos < width) ? base + swing : base) + $urandom_range(0, 15);
					send_item(psr_pkg::KIND_SAMPLE, (level > SAMPLE_MAX) ? SAMPLE_MAX : level);
					pos++;
					if (pos == period) begin
						period = $urandom_range(5, 24);
						width  = $urandom_range(1, period - 1);
						pos    = 0;
					end
				end
			end
		end
		idle_pct = 15;
	endtask

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin : check_results
		psr_pkg::result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with no item waiting for it");
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (out_ch.smoothed_sum !== want.smoothed_sum)
					report_mismatch($sformatf("smoothed_sum %0d, expected %0d",
						out_ch.smoothed_sum, want.smoothed_sum));
				if (out_ch.beat_seen !== want.beat_seen)
					report_mismatch($sformatf("beat_seen %b, expected %b",
						out_ch.beat_seen, want.beat_seen));
				if (out_ch.pulse_rate !== want.pulse_rate)
					report_mismatch($sformatf("pulse_rate %0d, expected %0d",
						out_ch.pulse_rate, want.pulse_rate));
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = psr_pkg::REG_LOW_THRESHOLD;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.kind   = psr_pkg::KIND_SAMPLE;
		in_ch.sample = '0;
		idle_pct     = 15;
		mismatches       = 0;
		results_checked  = 0;
		items_sent       = 0;
		ticks_sent       = 0;
		pulses_predicted = 0;
		foreach (sample_taps[k])
			sample_taps[k] = '0;
		foreach (pulse_history[k])
			pulse_history[k] = '0;
		last_sum           = '0;
		pulses_this_second = '0;
		rate_bpm           = '0;
		low_thr            = psr_pkg::LOW_RESET;
		high_thr           = psr_pkg::HIGH_RESET;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_threshold_settings();
		test_pulse_counter_saturation();
		test_random_pulse_trains();

		drain_results();
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_results.size()));
		$display("Sent %0d items (%0d ticks) over several threshold settings;",
			items_sent, ticks_sent);
		$display("checked %0d results with %0d pulses counted, including counter saturation.",
			results_checked, pulses_predicted);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== pulse_sensor_heart_rate_core.f =====
rtl/psr_pkg.sv
rtl/psr_in_if.sv
rtl/psr_out_if.sv
rtl/pulse_sensor_heart_rate_core.sv
tb/tb_top.sv
